FILE: rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg: shared definitions of the linear interpolation resampler
// sample and position formats, step limits, register indexes
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRAC_BITS     = 16;
    localparam int CHANNELS      = 2;
    localparam int STEP_BITS     = 21;
    localparam int PHASE_BITS    = 22;
    localparam int CCOUNT_BITS   = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = STEP_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [FRAC_BITS-1:0]          t_frac;
    typedef logic [STEP_BITS-1:0]          t_step;
    typedef logic [PHASE_BITS-1:0]         t_phase;
    typedef logic [CFG_IDX_BITS-1:0]       t_cfg_idx;

    // one source frame in position units
    localparam t_phase ONE_POS  = t_phase'(1) << FRAC_BITS;
    // step limits, 1/16 to 16 frames per output
    localparam t_step  STEP_MIN = t_step'(1) << (FRAC_BITS - 4);
    localparam t_step  STEP_MAX = t_step'(1) << (FRAC_BITS + 4);

    localparam t_step                  SPEED_RESET  = t_step'(1) << FRAC_BITS;
    localparam logic [CCOUNT_BITS-1:0] CCOUNT_RESET = CCOUNT_BITS'(2);
    localparam logic [CCOUNT_BITS-1:0] CCOUNT_MONO  = CCOUNT_BITS'(1);

    localparam t_cfg_idx REG_SPEED_STEP    = t_cfg_idx'(0);
    localparam t_cfg_idx REG_CHANNEL_COUNT = t_cfg_idx'(1);

endpackage

FILE: rtl/lir_lerp_unit.sv
// ----------------------------------------------------------------------------
// lir_lerp_unit: shared interpolation datapath
// a + floor((b - a) * frac / 2^FRAC_BITS), one channel per enabled cycle, registered
// ----------------------------------------------------------------------------
module lir_lerp_unit
    import lir_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_sample i_a,
    input  t_sample i_b,
    input  t_frac   i_frac,
    output t_sample o_res
);

    logic signed [SAMPLE_BITS:0]             diff;
    logic signed [FRAC_BITS:0]               frac_s;
    logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod;
    t_sample                                 r_res;

    assign diff   = (SAMPLE_BITS+1)'(i_b) - (SAMPLE_BITS+1)'(i_a);
    assign frac_s = $signed({1'b0, i_frac});
    assign prod   = (SAMPLE_BITS+FRAC_BITS+2)'(diff) * (SAMPLE_BITS+FRAC_BITS+2)'(frac_s);

    // arithmetic shift floors; the sum stays between a and b so low bits suffice
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= i_a + t_sample'(prod[FRAC_BITS +: SAMPLE_BITS]);
        end
    end

    assign o_res = r_res;

endmodule

FILE: rtl/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler: playback speed change by linear interpolation
// frames in, interpolated frames out at a programmable Q5.16 step
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | i_in_valid/o_in_stall | i_sample_ch0/ch1, i_last_frame
//  out     | output    | o_out_valid/i_out_stall | o_out_ch0/ch1, o_last_of_run,
//          |           |                      | o_clip_end
//  cfg     | input     | i_cfg_we             | i_cfg_index, i_cfg_data
//
//  o_in_stall is high from acceptance until the sequencer is back in idle: bookkeeping
//  in S_CHECK and S_POST, then per result channel 0 and channel 1 through the shared
//  multiplier, then the output register load; at most 32 results per frame
//  reset is synchronous, active low; step 1.0, two channels, empty history
//  a stalled output register holds the sequencer in its emit state
// ----------------------------------------------------------------------------
module linear_interp_resampler
    import lir_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input items
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_sample                  i_sample_ch0,
    input  t_sample                  i_sample_ch1,
    input  logic                     i_last_frame,
    // result items
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_sample                  o_out_ch0,
    output t_sample                  o_out_ch1,
    output logic                     o_last_of_run,
    output logic                     o_clip_end,
    // configuration writes
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_POST,
        S_CALC0,
        S_CALC1,
        S_EMIT
    } t_state;

    t_state                   r_state;
    t_step                    r_speed;
    logic [CCOUNT_BITS-1:0]   r_ccount;

    // history and position
    t_sample                  r_prev0;
    t_sample                  r_prev1;
    t_sample                  r_cur0;
    t_sample                  r_cur1;
    logic                     r_have_prev;
    logic                     r_last;
    logic                     r_flush;      // emitting tail copies of the last frame
    t_phase                   r_phase;
    t_sample                  r_res0;

    // output register
    logic                     r_out_valid;
    t_sample                  r_out_ch0;
    t_sample                  r_out_ch1;
    logic                     r_out_last;
    logic                     r_out_end;

    t_step                    step;
    t_phase                   n_phase;
    t_phase                   n_wrap;
    logic                     more;
    logic                     out_free;
    logic                     two_ch;
    logic                     unit_en;
    t_sample                  unit_a;
    t_sample                  unit_b;
    t_sample                  unit_res;

    // step saturated so that speed is never zero
    always_comb begin
        if (r_speed < STEP_MIN) begin
            step = STEP_MIN;
        end else if (r_speed > STEP_MAX) begin
            step = STEP_MAX;
        end else begin
            step = r_speed;
        end
    end

    assign n_phase = r_phase + t_phase'(step);
    assign n_wrap  = n_phase - ONE_POS;

    // does another result follow the one being emitted
    always_comb begin
        if (r_flush) begin
            more = (n_phase < ONE_POS);
        end else begin
            more = (n_phase < ONE_POS) || (r_last && (n_wrap < ONE_POS));
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign two_ch   = (CHANNELS >= 2) && (r_ccount != CCOUNT_MONO);

    // shared multiplier: channel 0 in S_CALC0, channel 1 in S_CALC1
    assign unit_en = (r_state == S_CALC0) || (r_state == S_CALC1);
    assign unit_a  = (r_state == S_CALC1) ? r_prev1 : r_prev0;
    assign unit_b  = (r_state == S_CALC1) ? r_cur1  : r_cur0;

    lir_lerp_unit u_lerp (
        .i_clk  (i_clk),
        .i_en   (unit_en),
        .i_a    (unit_a),
        .i_b    (unit_b),
        .i_frac (r_phase[FRAC_BITS-1:0]),
        .o_res  (unit_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= SPEED_RESET;
            r_ccount    <= CCOUNT_RESET;
            r_prev0     <= '0;
            r_prev1     <= '0;
            r_have_prev <= 1'b0;
            r_last      <= 1'b0;
            r_flush     <= 1'b0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SPEED_STEP:    r_speed  <= i_cfg_data[STEP_BITS-1:0];
                    REG_CHANNEL_COUNT: r_ccount <= i_cfg_data[CCOUNT_BITS-1:0];
                    default: ;
                endcase
            end

            // load a new result, or drop the one taken downstream
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cur0  <= i_sample_ch0;
                        r_cur1  <= i_sample_ch1;
                        r_last  <= i_last_frame;
                        r_flush <= 1'b0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_have_prev && (r_phase < ONE_POS)) begin
                        r_state <= S_CALC0;
                    end else begin
                        // no result between the previous frame and this one
                        if (r_have_prev) begin
                            r_phase <= r_phase - ONE_POS;
                        end
                        r_prev0     <= r_cur0;
                        r_prev1     <= r_cur1;
                        r_have_prev <= 1'b1;
                        r_state     <= S_POST;
                    end
                end
                S_POST: begin
                    // prev now equals cur, so the unit repeats the frame
                    if (r_last && (r_phase < ONE_POS)) begin
                        r_flush <= 1'b1;
                        r_state <= S_CALC0;
                    end else begin
                        if (r_last) begin
                            r_prev0     <= '0;
                            r_prev1     <= '0;
                            r_have_prev <= 1'b0;
                            r_phase     <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_CALC0: begin
                    r_state <= S_CALC1;
                end
                S_CALC1: begin
                    r_res0  <= unit_res;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_ch0   <= r_res0;
                        r_out_ch1   <= two_ch ? unit_res : t_sample'(0);
                        r_out_last  <= !more;
                        r_out_end   <= !more && r_last;
                        if (n_phase < ONE_POS) begin
                            r_phase <= n_phase;
                            r_state <= S_CALC0;
                        end else if (r_flush) begin
                            // clip done, clear history for the next clip
                            r_prev0     <= '0;
                            r_prev1     <= '0;
                            r_have_prev <= 1'b0;
                            r_phase     <= '0;
                            r_flush     <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_phase     <= n_wrap;
                            r_prev0     <= r_cur0;
                            r_prev1     <= r_cur1;
                            r_have_prev <= 1'b1;
                            r_state     <= S_POST;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_ch0     = r_out_ch0;
    assign o_out_ch1     = r_out_ch1;
    assign o_last_of_run = r_out_last;
    assign o_clip_end    = r_out_end;

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for linear_interp_resampler
// frames go in over the valid/stall channel; a scoreboard class runs its own
// interpolation of each accepted frame and compares every output item field
// by field; both channels idle at random; step and channel count change
// between phases
// ----------------------------------------------------------------------------
module tb_top;
    import lir_pkg::*;

    localparam int  DRAIN_CYCLES  = 120;
    localparam int  RANDOM_ITEMS  = 100;
    localparam int  TIMEOUT_UNITS = 15_000_000;

    // one output item as seen on the result channel
    typedef struct {
        t_sample ch0;
        t_sample ch1;
        logic    last_of_run;
        logic    clip_end;
    } t_frame_out;

    // interpolation predictor plus queue of outputs not yet seen
    class resample_scoreboard;
        t_step                  step_reg;
        logic [CCOUNT_BITS-1:0] ccount_reg;
        t_sample                prev0;
        t_sample                prev1;
        bit                     have_prev;
        t_phase                 phase;
        t_frame_out             expected_frames[$];
        int                     errors;

        function new();
            step_reg   = SPEED_RESET;
            ccount_reg = CCOUNT_RESET;
            errors     = 0;
            clear_history();
        endfunction

        function void clear_history();
            prev0     = '0;
            prev1     = '0;
            have_prev = 1'b0;
            phase     = '0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_SPEED_STEP) begin
                step_reg = t_step'(data);
            end else if (idx == REG_CHANNEL_COUNT) begin
                ccount_reg = data[CCOUNT_BITS-1:0];
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // a + floor((b - a) * frac / 2^FRAC_BITS)
        function t_sample blend(t_sample a, t_sample b, t_phase frac);
            longint prod;
            prod = (longint'(b) - longint'(a)) * longint'(frac);
            return t_sample'(longint'(a) + (prod >>> FRAC_BITS));
        endfunction

        function void push_frame(t_sample c0, t_sample c1);
            t_frame_out f;
            f.ch0         = c0;
            f.ch1         = ((CHANNELS >= 2) && (ccount_reg != CCOUNT_MONO)) ? c1 : '0;
            f.last_of_run = 1'b0;
            f.clip_end    = 1'b0;
            expected_frames.insert(expected_frames.size(), f);
        endfunction

        function void note_frame(t_sample cur0, t_sample cur1, logic last);
            t_step      step;
            int         made;
            t_frame_out tail;
            made = 0;
            step = step_reg;
            if (step < STEP_MIN) step = STEP_MIN;
            if (step > STEP_MAX) step = STEP_MAX;
            // outputs that fall between the previous frame and this one
            if (have_prev) begin
                while (phase < ONE_POS && made < 32) begin
                    push_frame(blend(prev0, cur0, phase), blend(prev1, cur1, phase));
                    made++;
                    phase = phase + step;
                end
                phase = phase - ONE_POS;
            end
            prev0     = cur0;
            prev1     = cur1;
            have_prev = 1'b1;
            // flush of the tail, repeating the final frame
            if (last) begin
                while (phase < ONE_POS && made < 32) begin
                    push_frame(cur0, cur1);
                    made++;
                    phase = phase + step;
                end
                clear_history();
            end
            if (made > 0) begin
                tail             = expected_frames[expected_frames.size() - 1];
                tail.last_of_run = 1'b1;
                tail.clip_end    = last;
                expected_frames[expected_frames.size() - 1] = tail;
            end
        endfunction

        function void check_output(t_sample c0, t_sample c1, logic lor, logic ce);
            t_frame_out exp_f;
            if (expected_frames.size() == 0) begin
                $display("%0t unexpected output item: ch0 %0d ch1 %0d last_of_run %0b clip_end %0b",
                         $time, c0, c1, lor, ce);
                errors++;
                return;
            end
            exp_f = expected_frames.pop_front();
            if (c0 !== exp_f.ch0) begin
                $display("%0t out_ch0 mismatch: expected %0d actual %0d", $time, exp_f.ch0, c0);
                errors++;
            end
            if (c1 !== exp_f.ch1) begin
                $display("%0t out_ch1 mismatch: expected %0d actual %0d", $time, exp_f.ch1, c1);
                errors++;
            end
            if (lor !== exp_f.last_of_run) begin
                $display("%0t last_of_run mismatch: expected %0b actual %0b",
                         $time, exp_f.last_of_run, lor);
                errors++;
            end
            if (ce !== exp_f.clip_end) begin
                $display("%0t clip_end mismatch: expected %0b actual %0b",
                         $time, exp_f.clip_end, ce);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_stall;
    t_sample                  i_sample_ch0 = '0;
    t_sample                  i_sample_ch1 = '0;
    logic                     i_last_frame = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall  = 1'b0;
    t_sample                  o_out_ch0;
    t_sample                  o_out_ch1;
    logic                     o_last_of_run;
    logic                     o_clip_end;
    logic                     i_cfg_we     = 1'b0;
    t_cfg_idx                 i_cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data   = '0;

    resample_scoreboard sb;
    bit                 quiet = 1'b0;   // no gaps and no stalls while set

    linear_interp_resampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_ch0  (i_sample_ch0),
        .i_sample_ch1  (i_sample_ch1),
        .i_last_frame  (i_last_frame),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_ch0     (o_out_ch0),
        .o_out_ch1     (o_out_ch1),
        .o_last_of_run (o_last_of_run),
        .o_clip_end    (o_clip_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)  return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 7))
            0:       return t_sample'(-32768);
            1:       return t_sample'(32767);
            2:       return t_sample'(0);
            3:       return t_sample'(-1);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // raw step values, out-of-range ones included to hit saturation
    function automatic logic [CFG_DATA_BITS-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_BITS'(STEP_MIN);
            1:       return CFG_DATA_BITS'(STEP_MAX);
            2:       return CFG_DATA_BITS'($urandom_range(0, STEP_MIN - 1));
            3:       return CFG_DATA_BITS'($urandom_range(STEP_MAX + 1, (1 << STEP_BITS) - 1));
            4:       return CFG_DATA_BITS'(SPEED_RESET);
            default: return CFG_DATA_BITS'($urandom_range(STEP_MIN, 2 * ONE_POS));
        endcase
    endfunction

    task automatic send_frame(input t_sample s0, input t_sample s1, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_sample_ch0 <= s0;
        i_sample_ch1 <= s1;
        i_last_frame <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_frame(s0, s1, last);
    endtask

    // both registers, one per cycle, enable held high across the pair
    task automatic write_config(input logic [CFG_DATA_BITS-1:0] step_data,
                                input logic [CCOUNT_BITS-1:0] ccount);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SPEED_STEP;
        i_cfg_data  <= step_data;
        @(posedge i_clk);
        sb.set_register(REG_SPEED_STEP, step_data);
        i_cfg_index <= REG_CHANNEL_COUNT;
        i_cfg_data  <= CFG_DATA_BITS'(ccount);
        @(posedge i_clk);
        sb.set_register(REG_CHANNEL_COUNT, CFG_DATA_BITS'(ccount));
        i_cfg_we    <= 1'b0;
    endtask

    // all expected outputs in, then room for an item that makes none
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result side: check accepted items, then pick the next stall state
    initial begin
        int  hold;
        logic stall_next;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_output(o_out_ch0, o_out_ch1, o_last_of_run, o_clip_end);
            end
            if (hold > 0) begin
                hold--;
            end else begin
                stall_next = !quiet && ($urandom_range(0, 2) == 0);
                hold       = pick_gap();
                i_out_stall <= stall_next;
            end
        end
    end

    initial begin
        int sent;
        int phase_len;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-frame clip at reset settings: one output repeating it
        send_frame(t_sample'(32767), t_sample'(-32768), 1'b1);
        // full-scale swings at unity speed
        send_frame(t_sample'(-32768), t_sample'(32767), 1'b0);
        send_frame(t_sample'(32767), t_sample'(-32768), 1'b0);
        send_frame(t_sample'(0), t_sample'(-1), 1'b0);
        send_frame(t_sample'(-1), t_sample'(0), 1'b1);
        wait_drained();

        // zero step saturates to 1/16, mono: 16 interpolated plus 16 tail outputs
        write_config('0, CCOUNT_MONO);
        send_frame(t_sample'(-32768), t_sample'(32767), 1'b0);
        send_frame(t_sample'(32767), t_sample'(-32768), 1'b1);
        wait_drained();

        // all-ones step saturates to 16, tail flush comes out empty
        write_config('1, 2'd3);
        send_frame(t_sample'(100), t_sample'(-100), 1'b0);
        send_frame(t_sample'(200), t_sample'(-200), 1'b0);
        send_frame(t_sample'(300), t_sample'(-300), 1'b0);
        send_frame(t_sample'(400), t_sample'(-400), 1'b1);
        wait_drained();

        // slowest legal step, channel count zero still means stereo,
        // negative differences exercise the floor
        write_config(CFG_DATA_BITS'(STEP_MIN), 2'd0);
        send_frame(t_sample'(-32768), t_sample'(32767), 1'b0);
        send_frame(t_sample'(12345), t_sample'(-23456), 1'b0);
        send_frame(t_sample'(-1), t_sample'(1), 1'b1);
        wait_drained();

        // fastest legal step on a single-frame clip
        write_config(CFG_DATA_BITS'(STEP_MAX), CCOUNT_RESET);
        send_frame(t_sample'(1), t_sample'(2), 1'b1);

        // random phases; clips run across phase boundaries so the step
        // also changes in the middle of a clip
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            write_config(pick_step(), CCOUNT_BITS'($urandom_range(0, 3)));
            quiet     = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(8, 24);
            repeat (phase_len) begin
                send_frame(pick_sample(), pick_sample(), $urandom_range(0, 5) == 0);
                sent++;
            end
        end
        wait_drained();

        if (sb.pending() != 0) begin
            $display("%0t %0d expected output items never arrived", $time, sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS linear_interp_resampler");
        end else begin
            $display("FAIL linear_interp_resampler");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_UNITS;
        $display("%0t timeout", $time);
        $display("FAIL linear_interp_resampler");
        $finish;
    end

endmodule
